### hdl/ppq_pkg.sv
// Package for the priority task queue: sizes, codes, slot and result types.
`default_nettype none
package ppq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NEST_DEPTH  = 8;

    localparam int QADDR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int NADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int NCNT_W  = $clog2(NEST_DEPTH + 1);

    localparam int PRIO_W   = 15;
    localparam int HANDLE_W = 16;

    localparam logic [PRIO_W-1:0] IDLE_RESET = 15'd9999;

    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_DISPATCH = 2'd1;
    localparam logic [1:0] REQ_FINISH   = 2'd2;
    localparam logic [1:0] REQ_POP      = 2'd3;

    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_FULL  = 3'd1;
    localparam logic [2:0] STAT_NEG   = 3'd2;
    localparam logic [2:0] STAT_NONE  = 3'd3;
    localparam logic [2:0] STAT_STACK = 3'd4;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PRIO_W-1:0]   prio;
    } slot_t;

    typedef struct packed {
        logic              push;
        logic              pop;
    } stack_ctrl_t;

    typedef struct packed {
        logic [QCNT_W-1:0]   queued;
        logic [PRIO_W-1:0]   running_level;
        logic [PRIO_W-1:0]   out_priority;
        logic [HANDLE_W-1:0] out_handle;
        logic                dispatched;
        logic [2:0]          status;
    } result_t;

    // physical slot of logical position off in the ring starting at base
    function automatic logic [QADDR_W-1:0] qwrap(input logic [QADDR_W-1:0] base,
                                                 input logic [QCNT_W-1:0]  off);
        logic [QCNT_W:0] sum;
        sum = {{(QCNT_W + 1 - QADDR_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (QCNT_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (QCNT_W + 1)'(QUEUE_DEPTH);
        end
        return sum[QADDR_W-1:0];
    endfunction

endpackage
`default_nettype wire

### hdl/ppq_slot_ram.sv
// Slot memory holding priority and handle of each waiting task.
`default_nettype none
module ppq_slot_ram (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [ppq_pkg::QADDR_W-1:0] wr_addr,
    input  wire ppq_pkg::slot_t        wr_data,
    input  wire logic [ppq_pkg::QADDR_W-1:0] rd_addr,
    output ppq_pkg::slot_t             rd_data
);
    import ppq_pkg::*;

    slot_t mem [QUEUE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

### hdl/ppq_level_stack.sv
// Nesting stack of saved running levels.
`default_nettype none
module ppq_level_stack (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ppq_pkg::stack_ctrl_t          ctrl,
    input  wire logic [ppq_pkg::PRIO_W-1:0]    push_level,
    output logic [ppq_pkg::PRIO_W-1:0]         top_level,
    output logic [ppq_pkg::NCNT_W-1:0]         count,
    output logic                               empty,
    output logic                               full
);
    import ppq_pkg::*;

    logic [PRIO_W-1:0] stack_reg [NEST_DEPTH];
    logic [NCNT_W-1:0] count_reg;
    logic [NCNT_W-1:0] count_next;
    logic [NCNT_W-1:0] top_pos;

    assign top_pos   = count_reg - NCNT_W'(1);
    assign top_level = stack_reg[top_pos[NADDR_W-1:0]];
    assign count     = count_reg;
    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= NCNT_W'(NEST_DEPTH));

    always_comb begin
        count_next = count_reg;
        if (ctrl.push && !full) begin
            count_next = count_reg + NCNT_W'(1);
        end else if (ctrl.pop && !empty) begin
            count_next = top_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push && !full) begin
            stack_reg[count_reg[NADDR_W-1:0]] <= push_level;
        end
    end

endmodule
`default_nettype wire

### hdl/preemptive_priority_task_queue_core.sv
// Top level: sequencer, shared slot compare and result register of the task queue.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [15:0] priority_req, [31:16] task_handle | [1:0] req_type
//  m_      | out | handle, priority, level, queued         | [2:0] status, [3] dispatched
//  cfg_    | in  | cfg_wr_data = idle_level                | -
//
// Rejected inserts, finish, and dispatch or pop on an empty queue go straight to the
// output state; any other dispatch or pop first reads the head slot and compares it.
// Insert walks down from the tail with one slot read and one compare-and-write per
// step; once it has moved past all waiting tasks, a final step writes the new slot.
// Reset: synchronous, active low; queue and nesting stack come up empty.
// The block takes a new beat while a result waits on m_; a stalled m_ side
// holds the sequencer only at its last state.
`default_nettype none
module preemptive_priority_task_queue_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] priority_req, [31:16] task_handle
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [15:0] out_handle, [30:16] out_priority,
                                        // [45:31] running_level, [50:46] queued
    output logic [3:0]       m_tuser,   // [2:0] status, [3] dispatched
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data
);
    import ppq_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HEAD  = 3'd1;
    localparam logic [2:0] S_HCMP  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_PLACE = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [1:0]          req_reg, req_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [HANDLE_W-1:0] handle_reg, handle_next;
    logic [QCNT_W-1:0]   idx_reg, idx_next;
    logic [QADDR_W-1:0]  head_reg, head_next;
    logic [QCNT_W-1:0]   qcnt_reg, qcnt_next;
    logic [PRIO_W-1:0]   running_reg, running_next;
    logic [PRIO_W-1:0]   idle_reg, idle_next;
    result_t             res_reg, res_next;
    result_t             mres_reg, mres_next;
    logic                mvalid_reg, mvalid_next;

    logic                ram_wr_en;
    logic [QADDR_W-1:0]  ram_wr_addr;
    slot_t               ram_wr_data;
    logic [QADDR_W-1:0]  ram_rd_addr;
    slot_t               ram_rd_data;

    stack_ctrl_t         stk_ctrl;
    logic [PRIO_W-1:0]   stk_top;
    logic [NCNT_W-1:0]   stk_count;
    logic                stk_empty;
    logic                stk_full;

    logic                s_fire;
    slot_t               new_slot;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign new_slot = '{handle: handle_reg, prio: prio_reg};

    ppq_slot_ram u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ppq_level_stack u_level_stack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (stk_ctrl),
        .push_level (running_reg),
        .top_level  (stk_top),
        .count      (stk_count),
        .empty      (stk_empty),
        .full       (stk_full)
    );

    always_comb begin
        state_next   = state_reg;
        req_next     = req_reg;
        prio_next    = prio_reg;
        handle_next  = handle_reg;
        idx_next     = idx_reg;
        head_next    = head_reg;
        qcnt_next    = qcnt_reg;
        running_next = running_reg;
        idle_next    = idle_reg;
        res_next     = res_reg;
        mres_next    = mres_reg;
        mvalid_next  = mvalid_reg;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = qwrap(head_reg, idx_reg);
        ram_wr_data  = new_slot;
        ram_rd_addr  = qwrap(head_reg, idx_reg - QCNT_W'(1));
        stk_ctrl     = '{push: 1'b0, pop: 1'b0};

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        if (cfg_wr_en) begin
            idle_next = cfg_wr_data;
            if (stk_empty) begin
                running_next = cfg_wr_data;
            end
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    req_next    = s_tuser;
                    prio_next   = s_tdata[14:0];
                    handle_next = s_tdata[31:16];
                    res_next    = '{queued: qcnt_reg, running_level: running_reg,
                                    out_priority: '0, out_handle: '0,
                                    dispatched: 1'b0, status: STAT_OK};
                    state_next  = S_OUT;
                    case (s_tuser)
                        REQ_INSERT: begin
                            if (s_tdata[15]) begin
                                res_next.status = STAT_NEG;
                            end else if (qcnt_reg == QCNT_W'(QUEUE_DEPTH)) begin
                                res_next.status = STAT_FULL;
                            end else begin
                                idx_next   = qcnt_reg;
                                state_next = S_RD;
                                if (qcnt_reg == '0) begin
                                    state_next = S_PLACE;
                                end
                            end
                        end
                        REQ_DISPATCH, REQ_POP: begin
                            if (qcnt_reg == '0) begin
                                res_next.status = STAT_NONE;
                            end else begin
                                state_next = S_HEAD;
                            end
                        end
                        REQ_FINISH: begin
                            if (stk_empty) begin
                                res_next.status = STAT_STACK;
                            end else begin
                                stk_ctrl.pop           = 1'b1;
                                running_next           = stk_top;
                                res_next.running_level = stk_top;
                            end
                        end
                        default: begin
                            res_next.status = STAT_NONE;
                        end
                    endcase
                end
            end
            S_HEAD: begin
                ram_rd_addr = head_reg;
                state_next  = S_HCMP;
            end
            S_HCMP: begin
                state_next = S_OUT;
                if (req_reg == REQ_DISPATCH && running_reg <= ram_rd_data.prio) begin
                    res_next.status = STAT_NONE;
                end else if (req_reg == REQ_DISPATCH && stk_full) begin
                    res_next.status = STAT_STACK;
                end else begin
                    head_next             = qwrap(head_reg, QCNT_W'(1));
                    qcnt_next             = qcnt_reg - QCNT_W'(1);
                    res_next.queued       = qcnt_reg - QCNT_W'(1);
                    res_next.out_handle   = ram_rd_data.handle;
                    res_next.out_priority = ram_rd_data.prio;
                    if (req_reg == REQ_DISPATCH) begin
                        stk_ctrl.push          = 1'b1;
                        running_next           = ram_rd_data.prio;
                        res_next.running_level = ram_rd_data.prio;
                        res_next.dispatched    = 1'b1;
                    end
                end
            end
            S_RD: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                ram_wr_en = 1'b1;
                // move the older entry up one slot while it is not more urgent
                if (ram_rd_data.prio >= prio_reg) begin
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_reg - QCNT_W'(1);
                    state_next  = (idx_reg == QCNT_W'(1)) ? S_PLACE : S_RD;
                end else begin
                    qcnt_next       = qcnt_reg + QCNT_W'(1);
                    res_next.queued = qcnt_reg + QCNT_W'(1);
                    state_next      = S_OUT;
                end
            end
            S_PLACE: begin
                ram_wr_en       = 1'b1;
                qcnt_next       = qcnt_reg + QCNT_W'(1);
                res_next.queued = qcnt_reg + QCNT_W'(1);
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!mvalid_reg || m_tready) begin
                    mres_next   = res_reg;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            qcnt_reg    <= '0;
            running_reg <= IDLE_RESET;
            idle_reg    <= IDLE_RESET;
            mvalid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            qcnt_reg    <= qcnt_next;
            running_reg <= running_next;
            idle_reg    <= idle_next;
            mvalid_reg  <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        prio_reg   <= prio_next;
        handle_reg <= handle_next;
        idx_reg    <= idx_next;
        res_reg    <= res_next;
        mres_reg   <= mres_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = {mres_reg.dispatched, mres_reg.status};
    assign m_tdata  = {5'd0, mres_reg.queued, mres_reg.running_level,
                       mres_reg.out_priority, mres_reg.out_handle};

`ifndef NO_ASSERTIONS
    a_qcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stk_count <= NCNT_W'(NEST_DEPTH))
        else $error("nesting stack count above depth");

    a_disp_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == STAT_OK)
        else $error("dispatched result without ok status");

    a_wr_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> state_reg == S_CMP || state_reg == S_PLACE)
        else $error("slot write outside insert walk");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("ready right after accepted beat");
`endif

endmodule
`default_nettype wire

### tb/task_queue_checker.sv
// Checker for the task queue: predicts every result from the accepted requests and compares.
module task_queue_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] priority_req, [31:16] task_handle
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [55:0] m_tdata,   // [15:0] out_handle, [30:16] out_priority,
                                        // [45:31] running_level, [50:46] queued
    input  wire logic [3:0]  m_tuser,   // [2:0] status, [3] dispatched
    input  wire logic        cfg_wr_en,
    input  wire logic [14:0] cfg_wr_data,
    output int               mismatches,
    output int               outstanding,
    output int               results_checked,
    output logic [4:0]       status_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppq_pkg::*;

    typedef struct packed {
        logic [1:0]          req;
        logic [15:0]         prio;
        logic [HANDLE_W-1:0] handle;
    } request_t;

    // shadow of the queue, sorted ascending by priority
    logic [PRIO_W-1:0]   task_prio [QUEUE_DEPTH];
    logic [HANDLE_W-1:0] task_handle [QUEUE_DEPTH];
    int unsigned         tasks_waiting;
    logic [PRIO_W-1:0]   saved_level [NEST_DEPTH];
    int unsigned         nest_used;
    logic [PRIO_W-1:0]   idle_level;
    logic [PRIO_W-1:0]   run_level;

    result_t expected_results[$];

    function automatic void remove_head_task();
        int i;
        for (i = 1; i < int'(tasks_waiting); i++) begin
            task_prio[i-1]   = task_prio[i];
            task_handle[i-1] = task_handle[i];
        end
        tasks_waiting--;
    endfunction

    function automatic result_t predict_request(request_t rq);
        result_t r;
        int      pos;
        int      i;
        r = '0;
        r.status = STAT_OK;
        case (rq.req)
            REQ_INSERT: begin
                if (rq.prio[15]) begin
                    r.status = STAT_NEG;
                end else if (tasks_waiting >= QUEUE_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    // ties land in front, so the newest equal-priority task goes first
                    pos = 0;
                    while (pos < int'(tasks_waiting) && task_prio[pos] < rq.prio[14:0]) begin
                        pos++;
                    end
                    for (i = int'(tasks_waiting); i > pos; i--) begin
                        task_prio[i]   = task_prio[i-1];
                        task_handle[i] = task_handle[i-1];
                    end
                    task_prio[pos]   = rq.prio[14:0];
                    task_handle[pos] = rq.handle;
                    tasks_waiting++;
                end
            end
            REQ_DISPATCH: begin
                if (tasks_waiting == 0 || run_level <= task_prio[0]) begin
                    r.status = STAT_NONE;
                end else if (nest_used >= NEST_DEPTH) begin
                    r.status = STAT_STACK;
                end else begin
                    r.out_handle   = task_handle[0];
                    r.out_priority = task_prio[0];
                    r.dispatched   = 1'b1;
                    remove_head_task();
                    saved_level[nest_used] = run_level;
                    nest_used++;
                    run_level = r.out_priority;
                end
            end
            REQ_FINISH: begin
                if (nest_used == 0) begin
                    r.status = STAT_STACK;
                end else begin
                    nest_used--;
                    run_level = saved_level[nest_used];
                end
            end
            default: begin
                if (tasks_waiting == 0) begin
                    r.status = STAT_NONE;
                end else begin
                    r.out_handle   = task_handle[0];
                    r.out_priority = task_prio[0];
                    remove_head_task();
                end
            end
        endcase
        r.running_level = run_level;
        r.queued        = tasks_waiting[QCNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("[%0t] mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        end
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result beat with no request pending", 64'(got), 64'(0));
        end else begin
            want = expected_results.pop_front();
            results_checked++;
            if (got.status !== want.status)
                report_mismatch("status", 64'(got.status), 64'(want.status));
            if (got.dispatched !== want.dispatched)
                report_mismatch("dispatched", 64'(got.dispatched), 64'(want.dispatched));
            if (got.out_handle !== want.out_handle)
                report_mismatch("out_handle", 64'(got.out_handle), 64'(want.out_handle));
            if (got.out_priority !== want.out_priority)
                report_mismatch("out_priority", 64'(got.out_priority),
                                64'(want.out_priority));
            if (got.running_level !== want.running_level)
                report_mismatch("running_level", 64'(got.running_level),
                                64'(want.running_level));
            if (got.queued !== want.queued)
                report_mismatch("queued", 64'(got.queued), 64'(want.queued));
            if (want.status <= STAT_STACK) status_seen[want.status] = 1'b1;
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t  seen;
        request_t rq;
        if (!aresetn) begin
            idle_level      = IDLE_RESET;
            run_level       = IDLE_RESET;
            tasks_waiting   = 0;
            nest_used       = 0;
            results_checked = 0;
            status_seen     = '0;
            expected_results.delete();
        end else begin
            // register writes only happen while nothing is in flight
            if (cfg_wr_en) begin
                idle_level = cfg_wr_data;
                if (nest_used == 0) run_level = idle_level;
            end
            if (m_tvalid && m_tready) begin
                seen               = '0;
                seen.out_handle    = m_tdata[15:0];
                seen.out_priority  = m_tdata[30:16];
                seen.running_level = m_tdata[45:31];
                seen.queued        = m_tdata[50:46];
                seen.status        = m_tuser[2:0];
                seen.dispatched    = m_tuser[3];
                check_result(seen);
            end
            if (s_tvalid && s_tready) begin
                rq.req    = s_tuser;
                rq.prio   = s_tdata[15:0];
                rq.handle = s_tdata[31:16];
                expected_results.push_back(predict_request(rq));
            end
        end
        outstanding = expected_results.size();
    end

endmodule

### tb/tb_preemptive_priority_task_queue_core.sv
// Testbench top: drives directed and random task requests into the queue and gives the verdict.
module tb_preemptive_priority_task_queue_core;
    timeunit 1ns;
    timeprecision 1ps;
    import ppq_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int QUIET_TAIL    = 200;   // last requests run without idling
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 48;    // longest insert walks all slots

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic [31:0] s_tdata     = '0;
    logic [1:0]  s_tuser     = '0;
    logic        m_tready    = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [14:0] cfg_wr_data = '0;
    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [55:0] m_tdata;
    wire logic [3:0]  m_tuser;

    int         mismatches;
    int         outstanding;
    int         results_checked;
    logic [4:0] status_seen;

    bit                jitter      = 1'b0;
    int                stall_left  = 0;
    int                cycle_count = 0;
    int                sent_total  = 0;
    int                sent_kind [4] = '{0, 0, 0, 0};
    int                idle_writes = 0;
    logic [PRIO_W-1:0] idle_now    = IDLE_RESET;

    always #1 aclk = ~aclk;

    preemptive_priority_task_queue_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    task_queue_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .status_seen     (status_seen)
    );

    // result side back-pressure in random bursts while jitter is on
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (aresetn && jitter && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     outstanding);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] req, input logic [15:0] prio,
                             input logic [15:0] handle);
        if (jitter && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {handle, prio};
        s_tuser  <= req;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_total++;
        sent_kind[req]++;
    endtask

    // hold the sender until every pending result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_idle_level(input logic [14:0] level);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= level;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        idle_now = level;
        idle_writes++;
    endtask

    // mostly a narrow range so equal priorities are common
    function automatic logic [15:0] rand_prio();
        case ($urandom_range(0, 9))
            0:       return {1'b1, 15'($urandom)};
            1:       return {1'b0, 15'($urandom)};
            2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h0000;
            default: return 16'($urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [1:0] rand_req();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 8) return REQ_INSERT;
        if (pick < 13) return REQ_DISPATCH;
        if (pick < 16) return REQ_FINISH;
        return REQ_POP;
    endfunction

    initial begin
        int phase;
        int k;
        int p;
        int step;
        int random_end;
        logic [14:0] level;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty queue and empty nesting stack
        send_beat(REQ_FINISH, 16'h0000, 16'h0000);
        send_beat(REQ_DISPATCH, 16'hFFFF, 16'hFFFF);
        send_beat(REQ_POP, 16'h0000, 16'h0000);
        // negative priorities are rejected
        send_beat(REQ_INSERT, 16'h8000, 16'hFFFF);
        send_beat(REQ_INSERT, 16'hFFFF, 16'h1234);
        send_beat(REQ_INSERT, 16'h7FFF, 16'hFFFF);
        send_beat(REQ_INSERT, 16'h0000, 16'h0000);
        send_beat(REQ_INSERT, 16'd100, 16'h1111);
        send_beat(REQ_INSERT, 16'd100, 16'h2222);
        send_beat(REQ_DISPATCH, 16'h0000, 16'h0000);
        send_beat(REQ_DISPATCH, 16'h0000, 16'h0000);   // head not more urgent
        // new idle level while a task runs must not touch the running level
        settle();
        set_idle_level(15'h7FFF);
        send_beat(REQ_FINISH, 16'h0000, 16'h0000);
        send_beat(REQ_DISPATCH, 16'h0000, 16'h0000);   // newest of the tie first
        send_beat(REQ_FINISH, 16'h0000, 16'h0000);
        send_beat(REQ_POP, 16'h0000, 16'h0000);
        send_beat(REQ_DISPATCH, 16'h0000, 16'h0000);
        settle();
        set_idle_level(15'h7FFF);
        send_beat(REQ_DISPATCH, 16'h0000, 16'h0000);   // equal to running level
        settle();
        set_idle_level(15'h0000);
        send_beat(REQ_POP, 16'h0000, 16'h0000);
        send_beat(REQ_POP, 16'h0000, 16'h0000);

        random_end = sent_total + RANDOM_ITEMS;
        phase = 0;
        while (sent_total < random_end) begin
            settle();
            jitter <= (phase % 4 != 3) && (sent_total < random_end - QUIET_TAIL);
            case (phase % 6)
                0:       level = 15'h7FFF;
                3:       level = 15'h0000;
                5:       level = IDLE_RESET;
                default: level = 15'($urandom);
            endcase
            set_idle_level(level);
            case (phase % 3)
                0: begin
                    // drain, then nest ever more urgent tasks past the stack depth
                    repeat (QUEUE_DEPTH + 1) send_beat(REQ_POP, 16'($urandom), 16'($urandom));
                    step = (int'(idle_now) / 12 > 0) ? int'(idle_now) / 12 : 1;
                    for (k = 0; k < NEST_DEPTH + 2; k++) begin
                        p = int'(idle_now) - 1 - k * step;
                        if (p < 0) p = 0;
                        send_beat(REQ_INSERT, 16'(p), 16'($urandom));
                        send_beat(REQ_DISPATCH, 16'($urandom), 16'($urandom));
                        if ($urandom_range(0, 3) == 0)
                            send_beat(rand_req(), rand_prio(), 16'($urandom));
                    end
                    repeat (NEST_DEPTH + 2) begin
                        send_beat(REQ_FINISH, 16'($urandom), 16'($urandom));
                        if ($urandom_range(0, 3) == 0)
                            send_beat(REQ_POP, 16'($urandom), 16'($urandom));
                    end
                end
                1: begin
                    // run the queue into its full limit, then work it down
                    repeat (QUEUE_DEPTH + $urandom_range(1, 3))
                        send_beat(REQ_INSERT, rand_prio(), 16'($urandom));
                    repeat ($urandom_range(10, 24))
                        send_beat($urandom_range(0, 1) ? REQ_DISPATCH :
                                  ($urandom_range(0, 1) ? REQ_POP : REQ_FINISH),
                                  16'($urandom), 16'($urandom));
                end
                default: begin
                    repeat ($urandom_range(30, 80))
                        send_beat(rand_req(), rand_prio(), 16'($urandom));
                end
            endcase
            phase++;
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("sent %0d requests: %0d inserts, %0d dispatches, %0d finishes, %0d pops",
                 sent_total, sent_kind[REQ_INSERT], sent_kind[REQ_DISPATCH],
                 sent_kind[REQ_FINISH], sent_kind[REQ_POP]);
        $display("checked %0d results under %0d idle-level writes, status codes hit %05b",
                 results_checked, idle_writes, status_seen);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
hdl/ppq_pkg.sv
hdl/ppq_slot_ram.sv
hdl/ppq_level_stack.sv
hdl/preemptive_priority_task_queue_core.sv
tb/task_queue_checker.sv
tb/tb_preemptive_priority_task_queue_core.sv
